[sv/slr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants for the servo linear position ramp generator.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam int ANGLE_W = 16;
	localparam int DUR_W   = 16;
	localparam int CH_W    = 3;

	localparam int                 CHANNELS_DEF       = 8;
	localparam int                 FRACTION_BITS_DEF  = 16;
	localparam logic [ANGLE_W-1:0] START_POSITION_DEF = 16'd135;
	localparam logic [DUR_W-1:0]   MAX_DURATION_RST   = 16'd1000;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic RES_ACK   = 1'b0;
	localparam logic RES_ANGLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_SCAN,
		ST_DIV,
		ST_STEP,
		ST_EMIT
	} slr_state_t;

	typedef struct packed {
		logic               result_kind;
		logic [CH_W-1:0]    servo_channel;
		logic [ANGLE_W-1:0] angle_out;
		logic               accepted;
		logic               last_of_run;
	} slr_res_t;

endpackage

[sv/slr_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_in_if / slr_out_if
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface slr_in_if;
	import slr_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [CH_W-1:0]    channel;
	logic [ANGLE_W-1:0] position;
	logic [DUR_W-1:0]   duration;

	modport source (output valid, kind, channel, position, duration, input ready);
	modport sink   (input valid, kind, channel, position, duration, output ready);
endinterface

interface slr_out_if;
	import slr_pkg::*;

	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [CH_W-1:0]    servo_channel;
	logic [ANGLE_W-1:0] angle_out;
	logic               accepted;
	logic               last_of_run;

	modport source (output valid, result_kind, servo_channel, angle_out, accepted,
		last_of_run, input ready);
	modport sink   (input valid, result_kind, servo_channel, angle_out, accepted,
		last_of_run, output ready);
endinterface

[sv/slr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slr_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_nxt;

	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign diff    = trial - {1'b0, den_q};
	assign ge      = trial >= {1'b0, den_q};
	assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

[sv/slr_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_engine
// Per-channel ramp state and the sequencer that walks the channels on a tick.
// ----------------------------------------------------------------------------
module slr_engine import slr_pkg::*; #(
	parameter int                 CHANNELS       = CHANNELS_DEF,
	parameter int                 FRACTION_BITS  = FRACTION_BITS_DEF,
	parameter logic [ANGLE_W-1:0] START_POSITION = START_POSITION_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	slr_in_if.sink           items,
	input  logic [DUR_W-1:0] max_duration,
	output logic             res_valid,
	input  logic             res_ready,
	output slr_res_t         res
);

	localparam int CIDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ACC_W      = ANGLE_W + FRACTION_BITS;
	localparam int STEP_W     = ACC_W + 1;
	localparam int CH_LIM_W   = CH_W + 1;
	localparam logic [CH_LIM_W-1:0] CH_LIMIT = CH_LIM_W'(CHANNELS);

	slr_state_t state_q, state_d;

	logic [ANGLE_W-1:0]       pend_tgt_q   [CHANNELS];
	logic [DUR_W-1:0]         pend_ticks_q [CHANNELS];
	logic [ANGLE_W-1:0]       cur_q        [CHANNELS];
	logic [ACC_W-1:0]         acc_q        [CHANNELS];
	logic signed [STEP_W-1:0] step_q       [CHANNELS];
	logic [DUR_W-1:0]         left_q       [CHANNELS];
	logic [ANGLE_W-1:0]       mtgt_q       [CHANNELS];

	logic [CIDX_W-1:0]   c_q;
	logic [CHANNELS-1:0] mask_q;
	logic [CHANNELS-1:0] mask_now;
	logic [CHANNELS-1:0] mask_hi;
	logic [CH_W-1:0]     ch_q;
	logic                ok_q;

	logic in_acc, ch_ok, dur_ok, cmd_ok;
	logic [CIDX_W-1:0] cmd_idx;
	logic cmd_wr, div_start, div_wr, step_wr, advance, emit_last, c_last;

	logic [ANGLE_W-1:0]       sel_tgt, sel_cur, sel_mtgt;
	logic [DUR_W-1:0]         sel_ticks, sel_left, sel_d, left_m1;
	logic [ACC_W-1:0]         sel_acc, acc_new;
	logic signed [STEP_W-1:0] sel_step, step_new;
	logic signed [ACC_W+1:0]  sum;
	logic                     up;
	logic [ANGLE_W-1:0]       mag;
	logic                     div_done;
	logic [ACC_W-1:0]         quot;

	assign in_acc  = items.valid & items.ready;
	assign cmd_idx = items.channel[CIDX_W-1:0];
	assign ch_ok   = {1'b0, items.channel} < CH_LIMIT;
	assign dur_ok  = (items.duration != '0) && (items.duration <= max_duration);
	assign cmd_ok  = ch_ok & dur_ok;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			mask_now[i] = (left_q[i] != '0) || (pend_tgt_q[i] != cur_q[i]);
		end
	end

	assign sel_tgt   = pend_tgt_q[c_q];
	assign sel_ticks = pend_ticks_q[c_q];
	assign sel_cur   = cur_q[c_q];
	assign sel_acc   = acc_q[c_q];
	assign sel_step  = step_q[c_q];
	assign sel_left  = left_q[c_q];
	assign sel_mtgt  = mtgt_q[c_q];

	assign sel_d   = (sel_ticks == '0) ? DUR_W'(1) : sel_ticks;
	assign up      = sel_tgt > sel_cur;
	assign mag     = up ? (sel_tgt - sel_cur) : (sel_cur - sel_tgt);
	assign step_new = up ? $signed({1'b0, quot}) : -$signed({1'b0, quot});

	assign left_m1 = sel_left - 1'b1;
	assign sum     = $signed({2'b00, sel_acc}) + $signed({sel_step[STEP_W-1], sel_step});
	assign acc_new = sum[ACC_W+1] ? '0 : sum[ACC_W-1:0];

	assign mask_hi   = (mask_q >> c_q) >> 1;
	assign emit_last = mask_hi == '0;
	assign c_last    = c_q == CIDX_W'(CHANNELS - 1);

	slr_div #(
		.NUM_W (ACC_W),
		.DEN_W (DUR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag, {FRACTION_BITS{1'b0}}}),
		.divisor  (sel_d),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		items.ready = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		cmd_wr      = 1'b0;
		div_start   = 1'b0;
		div_wr      = 1'b0;
		step_wr     = 1'b0;
		advance     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
				if (in_acc) begin
					if (items.kind == KIND_CMD) begin
						cmd_wr  = cmd_ok;
						state_d = ST_ACK;
					end else if (mask_now != '0) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_ACK: begin
				res_valid         = 1'b1;
				res.result_kind   = RES_ACK;
				res.servo_channel = ch_q;
				res.accepted      = ok_q;
				res.last_of_run   = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!mask_q[c_q]) begin
					if (c_last) begin
						state_d = ST_IDLE;
					end else begin
						advance = 1'b1;
					end
				end else if (sel_left != '0) begin
					state_d = ST_STEP;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					div_wr  = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				step_wr = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				res_valid         = 1'b1;
				res.result_kind   = RES_ANGLE;
				res.servo_channel = CH_W'(c_q);
				res.angle_out     = sel_cur;
				res.last_of_run   = emit_last;
				if (res_ready) begin
					if (emit_last) begin
						state_d = ST_IDLE;
					end else begin
						advance = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
		end else if (in_acc) begin
			c_q <= '0;
		end else if (advance) begin
			c_q <= c_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mask_q <= mask_now;
			ch_q   <= items.channel;
			ok_q   <= cmd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pend_tgt_q[i]   <= START_POSITION;
				pend_ticks_q[i] <= DUR_W'(1);
				cur_q[i]        <= START_POSITION;
				acc_q[i]        <= {START_POSITION, {FRACTION_BITS{1'b0}}};
				step_q[i]       <= '0;
				left_q[i]       <= '0;
				mtgt_q[i]       <= START_POSITION;
			end
		end else begin
			if (cmd_wr) begin
				pend_tgt_q[cmd_idx]   <= items.position;
				pend_ticks_q[cmd_idx] <= items.duration;
			end
			if (div_wr) begin
				step_q[c_q] <= step_new;
				acc_q[c_q]  <= {sel_cur, {FRACTION_BITS{1'b0}}};
				left_q[c_q] <= sel_d;
				mtgt_q[c_q] <= sel_tgt;
			end
			if (step_wr) begin
				left_q[c_q] <= left_m1;
				if (left_m1 == '0) begin
					acc_q[c_q] <= {sel_mtgt, {FRACTION_BITS{1'b0}}};
					cur_q[c_q] <= sel_mtgt;
				end else begin
					acc_q[c_q] <= acc_new;
					cur_q[c_q] <= acc_new[ACC_W-1:FRACTION_BITS];
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_emit_masked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> mask_q[c_q])
		else $error("angle beat for a channel that was not due");

	a_step_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> sel_left != '0)
		else $error("step taken with no steps left");

	a_final_on_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && sel_left == '0 |-> sel_cur == sel_mtgt)
		else $error("final step did not land on target");
`endif

endmodule

[sv/servo_linear_position_ramp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_linear_position_ramp
// Multi-channel servo ramp generator with one shared serial divider.
// ----------------------------------------------------------------------------
// A move command is acknowledged from the ACK state through the output
// register. A tick walks the channels in order: an idle channel is only
// scanned, a channel already moving passes through SCAN, STEP and EMIT, and
// a channel that starts a move adds the step division on the shared
// one-bit-per-cycle divider; a tick also waits on any output stall.
// Items are taken one at a time; the output register frees the engine as
// soon as a beat is loaded.
// ----------------------------------------------------------------------------
module servo_linear_position_ramp import slr_pkg::*; #(
	parameter int                 CHANNELS       = CHANNELS_DEF,
	parameter int                 FRACTION_BITS  = FRACTION_BITS_DEF,
	parameter logic [ANGLE_W-1:0] START_POSITION = START_POSITION_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	slr_in_if.sink           items,
	slr_out_if.source        results,
	input  logic             cfg_we,
	input  logic [DUR_W-1:0] cfg_wdata
);

	logic [DUR_W-1:0] max_duration_q;
	logic             res_valid;
	logic             res_ready;
	slr_res_t         res;
	logic             out_valid_q;
	slr_res_t         out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duration_q <= MAX_DURATION_RST;
		end else if (cfg_we) begin
			max_duration_q <= cfg_wdata;
		end
	end

	slr_engine #(
		.CHANNELS       (CHANNELS),
		.FRACTION_BITS  (FRACTION_BITS),
		.START_POSITION (START_POSITION)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items),
		.max_duration (max_duration_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.result_kind   = out_res_q.result_kind;
	assign results.servo_channel = out_res_q.servo_channel;
	assign results.angle_out     = out_res_q.angle_out;
	assign results.accepted      = out_res_q.accepted;
	assign results.last_of_run   = out_res_q.last_of_run;

endmodule

[bench/servo_linear_position_ramp_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_linear_position_ramp_test
// Self-checking bench for the eight-channel servo ramp generator.
// Commands and ticks go in on a valid/ready channel. A tracker class keeps its
// own copy of the per-channel ramp state and queues the acknowledges and angle
// writes each accepted beat should cause. Every result beat is then checked
// against the oldest queued one. The run sweeps several duration limits and
// three patterns of stalls on both channels.
// ----------------------------------------------------------------------------
module servo_linear_position_ramp_test;
	import slr_pkg::*;

	localparam int SETTLE    = 2 * CHANNELS_DEF * (FRACTION_BITS_DEF + 21);
	localparam int RAND_RUNS = 115;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic               kind;
		logic [CH_W-1:0]    channel;
		logic [ANGLE_W-1:0] position;
		logic [DUR_W-1:0]   duration;
	} ramp_item_t;

	class ramp_tracker;
		logic [DUR_W-1:0]   limit_ticks;
		logic [ANGLE_W-1:0] goal[CHANNELS_DEF];
		logic [DUR_W-1:0]   goal_ticks[CHANNELS_DEF];
		logic [ANGLE_W-1:0] angle[CHANNELS_DEF];
		longint             accum[CHANNELS_DEF];
		longint             step[CHANNELS_DEF];
		int unsigned        ticks_left[CHANNELS_DEF];
		logic [ANGLE_W-1:0] end_angle[CHANNELS_DEF];
		slr_res_t           due[$];
		int unsigned        errors;

		function new();
			limit_ticks = MAX_DURATION_RST;
			errors = 0;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				goal[c]       = START_POSITION_DEF;
				goal_ticks[c] = 1;
				angle[c]      = START_POSITION_DEF;
				accum[c]      = longint'(START_POSITION_DEF) << FRACTION_BITS_DEF;
				step[c]       = 0;
				ticks_left[c] = 0;
				end_angle[c]  = START_POSITION_DEF;
			end
		endfunction

		function void take_item(ramp_item_t it);
			slr_res_t           r;
			bit                 ok;
			int                 n;
			int unsigned        d;
			longint unsigned    mag;
			longint             st;
			longint             a;
			logic [CH_W-1:0]    chs[CHANNELS_DEF];
			logic [ANGLE_W-1:0] angs[CHANNELS_DEF];
			n = 0;
			if (it.kind == KIND_CMD) begin
				ok = (int'(it.channel) < CHANNELS_DEF) && (it.duration != 0) &&
					(it.duration <= limit_ticks);
				if (ok) begin
					goal[it.channel]       = it.position;
					goal_ticks[it.channel] = it.duration;
				end
				r.result_kind   = RES_ACK;
				r.servo_channel = it.channel;
				r.angle_out     = '0;
				r.accepted      = ok;
				r.last_of_run   = 1'b1;
				due.push_back(r);
				return;
			end
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				if (ticks_left[c] == 0 && goal[c] != angle[c]) begin
					d   = (goal_ticks[c] != 0) ? goal_ticks[c] : 1;
					mag = (goal[c] > angle[c]) ? (goal[c] - angle[c]) : (angle[c] - goal[c]);
					st  = longint'((mag << FRACTION_BITS_DEF) / d);
					step[c]       = (goal[c] > angle[c]) ? st : -st;
					accum[c]      = longint'(angle[c]) << FRACTION_BITS_DEF;
					ticks_left[c] = d;
					end_angle[c]  = goal[c];
				end
				if (ticks_left[c] > 0) begin
					ticks_left[c]--;
					if (ticks_left[c] == 0) begin
						accum[c] = longint'(end_angle[c]) << FRACTION_BITS_DEF;
						angle[c] = end_angle[c];
					end else begin
						a = accum[c] + step[c];
						if (a < 0)
							a = 0;
						accum[c] = a;
						angle[c] = ANGLE_W'(a >> FRACTION_BITS_DEF);
					end
					chs[n]  = CH_W'(c);
					angs[n] = angle[c];
					n++;
				end
			end
			for (int k = 0; k < n; k++) begin
				r.result_kind   = RES_ANGLE;
				r.servo_channel = chs[k];
				r.angle_out     = angs[k];
				r.accepted      = 1'b0;
				r.last_of_run   = (k == n - 1);
				due.push_back(r);
			end
		endfunction

		function void check_beat(slr_res_t got);
			slr_res_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected beat: kind=%0d ch=%0d angle=%0d acc=%0d last=%0d",
						got.result_kind, got.servo_channel, got.angle_out, got.accepted,
						got.last_of_run);
				return;
			end
			want = due.pop_front();
			if (got.result_kind !== want.result_kind ||
				got.servo_channel !== want.servo_channel ||
				got.angle_out !== want.angle_out ||
				got.accepted !== want.accepted ||
				got.last_of_run !== want.last_of_run) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display({"mismatch: exp kind=%0d ch=%0d angle=%0d acc=%0d last=%0d",
						" | got kind=%0d ch=%0d angle=%0d acc=%0d last=%0d"},
						want.result_kind, want.servo_channel, want.angle_out,
						want.accepted, want.last_of_run,
						got.result_kind, got.servo_channel, got.angle_out,
						got.accepted, got.last_of_run);
			end
		endfunction

		function int outstanding();
			return due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DUR_W-1:0] cfg_wdata;
	int               src_idle;
	int               snk_idle;

	slr_in_if  item_bus ();
	slr_out_if result_bus ();

	ramp_tracker tracker = new();

	servo_linear_position_ramp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_bus),
		.results   (result_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random back-pressure, check every accepted beat
	initial begin
		slr_res_t got;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				got.result_kind   = result_bus.result_kind;
				got.servo_channel = result_bus.servo_channel;
				got.angle_out     = result_bus.angle_out;
				got.accepted      = result_bus.accepted;
				got.last_of_run   = result_bus.last_of_run;
				tracker.check_beat(got);
			end
			result_bus.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic push_item(input ramp_item_t it);
		while ($urandom_range(99) < src_idle) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.kind     <= it.kind;
		item_bus.channel  <= it.channel;
		item_bus.position <= it.position;
		item_bus.duration <= it.duration;
		do
			@(posedge clk);
		while (item_bus.ready !== 1'b1);
		tracker.take_item(it);
	endtask

	task automatic push_cmd(input int ch, input int pos, input int dur);
		ramp_item_t it;
		it.kind     = KIND_CMD;
		it.channel  = CH_W'(ch);
		it.position = ANGLE_W'(pos);
		it.duration = DUR_W'(dur);
		push_item(it);
	endtask

	task automatic push_tick();
		ramp_item_t it;
		it.kind     = KIND_TICK;
		it.channel  = CH_W'($urandom_range(7));
		it.position = ANGLE_W'($urandom);
		it.duration = DUR_W'($urandom);
		push_item(it);
	endtask

	// a tick that moves nothing yields no beat, so allow the engine time to finish
	task automatic drain();
		item_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.outstanding() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= DUR_W'(value);
		@(posedge clk);
		tracker.limit_ticks = DUR_W'(value);
		cfg_we <= 1'b0;
	endtask

	function automatic ramp_item_t random_item();
		ramp_item_t  it;
		int unsigned lim;
		int unsigned p;
		int          near;
		lim = tracker.limit_ticks;
		it.kind     = ($urandom_range(99) < 55) ? KIND_TICK : KIND_CMD;
		it.channel  = CH_W'($urandom_range(7));
		it.position = ANGLE_W'($urandom);
		it.duration = DUR_W'($urandom);
		if (it.kind == KIND_TICK)
			return it;
		p = $urandom_range(99);
		if (p < 78)
			it.duration = DUR_W'($urandom_range(1, (lim < 12) ? lim : 12));
		else if (p < 86)
			it.duration = (lim < 65535) ? DUR_W'(lim + 1) : DUR_W'(0);
		else if (p < 90)
			it.duration = '0;
		else if (p < 96) begin
			if (lim > 1000 && $urandom_range(3) != 0)
				it.duration = DUR_W'($urandom_range(1, 12));
			else
				it.duration = DUR_W'($urandom);
		end else
			it.duration = (lim <= 64) ? DUR_W'(lim) : DUR_W'($urandom_range(1, 12));
		p = $urandom_range(99);
		if (p < 10)
			it.position = '0;
		else if (p < 20)
			it.position = '1;
		else if (p < 45) begin
			near = int'(tracker.angle[it.channel]) + $urandom_range(40) - 20;
			if (near < 0)
				near = 0;
			if (near > 65535)
				near = 65535;
			it.position = ANGLE_W'(near);
		end
		return it;
	endfunction

	initial begin
		int limits[4];
		limits = '{1, 9, 1000, 65535};
		src_idle = 26;
		snk_idle = 49;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		item_bus.valid     <= 1'b0;
		item_bus.kind      <= KIND_TICK;
		item_bus.channel   <= '0;
		item_bus.position  <= '0;
		item_bus.duration  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, limits, every channel at once, retarget mid-move
		push_tick();
		push_cmd(0, START_POSITION_DEF, 5);
		push_cmd(1, 0, 0);
		push_cmd(1, START_POSITION_DEF, 1000);
		push_cmd(1, 0, 1001);
		push_cmd(2, 65535, 65535);
		push_cmd(0, 65535, 1);
		push_cmd(1, 0, 3);
		push_cmd(2, 65535, 7);
		push_cmd(3, 1000, 4);
		push_cmd(4, 0, 2);
		push_cmd(5, START_POSITION_DEF + 1, 3);
		push_cmd(6, START_POSITION_DEF - 1, 2);
		push_cmd(7, 40000, 5);
		push_tick();
		push_cmd(0, 0, 2);
		push_cmd(1, 500, 1);
		repeat (7) push_tick();
		push_cmd(7, 0, 1);
		push_tick();

		for (int k = 0; k < 4; k++) begin
			if (k == 2) begin
				src_idle = 49;
				snk_idle = 26;
			end
			if (k == 3) begin
				src_idle = 0;
				snk_idle = 0;
			end
			write_limit(limits[k]);
			for (int i = 0; i < RAND_RUNS; i++)
				push_item(random_item());
		end

		drain();
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
